// File: src/assert_macros.svh
// Assertion macros shared by the depth decimator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is high
`define DDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds through reset
`define DDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/ddd_pkg.sv
// Shared constants, types and helpers of the depth decimator
`timescale 1ns / 1ps
package ddd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int MAX_STEP    = 16;

  localparam int SIZE_W      = 11;
  localparam int COUNT_W     = 10;
  localparam int STEP_W      = 5;
  localparam int PHASE_W     = 4;
  localparam int DEPTH_W     = 16;
  localparam int VALUE_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = 5;

  localparam int LIMIT_STEPS = 11;
  localparam int LIMIT_CNT_W = 4;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OUTPUT_MODE     = 3'd0,
    REG_SOURCE_WIDTH    = 3'd1,
    REG_SOURCE_HEIGHT   = 3'd2,
    REG_COLUMN_STEP     = 3'd3,
    REG_ROW_STEP        = 3'd4,
    REG_NO_SAMPLE_CODE  = 3'd5,
    REG_SHADOW_CODE     = 3'd6,
    REG_DISPARITY_SCALE = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                 output_mode;
    logic [SIZE_W-1:0]    source_width;
    logic [SIZE_W-1:0]    source_height;
    logic [STEP_W-1:0]    column_step;
    logic [STEP_W-1:0]    row_step;
    logic [DEPTH_W-1:0]   no_sample_code;
    logic [DEPTH_W-1:0]   shadow_code;
    logic [VALUE_W-1:0]   disparity_scale;
  } cfg_t;

  // One kept sample on its way to the back end
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               bad;
    logic               row_end;
    logic               frame_end;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } head_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_DONE = 2'd2
  } back_state_t;

  // Clamp a frame size into 1..hi
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  // Clamp a decimation step into 1..MAX_STEP
  function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] v);
    logic [STEP_W-1:0] r;
    r = v;
    if (v == '0) r = STEP_W'(1);
    else if (v > STEP_W'(MAX_STEP)) r = STEP_W'(MAX_STEP);
    return r;
  endfunction

endpackage

// File: src/ddd_front.sv
// Front end: raster position tracking, decimation and sample classification
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ddd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  ddd_pkg::cfg_t                cfg,
  input  logic                         cfg_touch,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ddd_pkg::DEPTH_W-1:0]  depth_sample,
  input  logic                         frame_start,
  output ddd_pkg::push_t               push,
  input  logic                         q_full
);

  logic [ddd_pkg::SIZE_W-1:0]      w_cl, h_cl;
  logic [ddd_pkg::STEP_W-1:0]      cs_cl, rs_cl;

  // block limit setup
  logic                            busy;
  logic [ddd_pkg::LIMIT_CNT_W-1:0] lcnt, bit_sel;
  logic [ddd_pkg::PHASE_W-1:0]     col_rem, row_rem, col_rem_next, row_rem_next;
  logic [ddd_pkg::STEP_W-1:0]      col_trial, row_trial;
  logic [ddd_pkg::SIZE_W-1:0]      col_limit, row_limit;
  logic [ddd_pkg::SIZE_W-1:0]      col_last, row_last;

  // position
  logic [ddd_pkg::COUNT_W-1:0]     column_count, row_count, cc, rc;
  logic [ddd_pkg::PHASE_W-1:0]     column_phase, row_phase, cp, rp;
  logic                            accept, keep, last_col, last_row, bad;

  assign w_cl  = ddd_pkg::clamp_size(cfg.source_width, ddd_pkg::SIZE_W'(ddd_pkg::MAX_WIDTH));
  assign h_cl  = ddd_pkg::clamp_size(cfg.source_height, ddd_pkg::SIZE_W'(ddd_pkg::MAX_HEIGHT));
  assign cs_cl = ddd_pkg::clamp_step(cfg.column_step);
  assign rs_cl = ddd_pkg::clamp_step(cfg.row_step);

  // One bit of size mod step per cycle, most significant bit first
  always_comb begin
    bit_sel   = ddd_pkg::LIMIT_CNT_W'(ddd_pkg::LIMIT_STEPS - 1) - lcnt;
    col_trial = {col_rem, w_cl[bit_sel]};
    row_trial = {row_rem, h_cl[bit_sel]};
    if (col_trial >= cs_cl) col_rem_next = ddd_pkg::PHASE_W'(col_trial - cs_cl);
    else col_rem_next = col_trial[ddd_pkg::PHASE_W-1:0];
    if (row_trial >= rs_cl) row_rem_next = ddd_pkg::PHASE_W'(row_trial - rs_cl);
    else row_rem_next = row_trial[ddd_pkg::PHASE_W-1:0];
  end

  // Rerun the limit setup after reset and after every register write
  always_ff @(posedge clk) begin
    if (rst || cfg_touch) begin
      busy    <= 1'b1;
      lcnt    <= '0;
      col_rem <= '0;
      row_rem <= '0;
    end else if (busy) begin
      col_rem <= col_rem_next;
      row_rem <= row_rem_next;
      if (lcnt == ddd_pkg::LIMIT_CNT_W'(ddd_pkg::LIMIT_STEPS - 1)) begin
        busy      <= 1'b0;
        col_limit <= w_cl - ddd_pkg::SIZE_W'(col_rem_next);
        row_limit <= h_cl - ddd_pkg::SIZE_W'(row_rem_next);
      end else begin
        lcnt <= lcnt + 1'b1;
      end
    end
  end

  assign col_last = col_limit - ddd_pkg::SIZE_W'(cs_cl);
  assign row_last = row_limit - ddd_pkg::SIZE_W'(rs_cl);

  assign in_stall = busy || q_full;
  assign accept   = in_valid && !in_stall;

  // Classify the word against the current position
  always_comb begin
    cc = frame_start ? '0 : column_count;
    rc = frame_start ? '0 : row_count;
    cp = frame_start ? '0 : column_phase;
    rp = frame_start ? '0 : row_phase;
    keep = (cp == '0) && (rp == '0) &&
           ({1'b0, cc} < col_limit) && ({1'b0, rc} < row_limit);
    last_col = ({1'b0, cc} == col_last);
    last_row = ({1'b0, rc} == row_last);
    bad = (depth_sample == '0) || (depth_sample == cfg.no_sample_code) ||
          (depth_sample == cfg.shadow_code);
    push.push           = accept && keep;
    push.item.depth     = depth_sample;
    push.item.bad       = bad;
    push.item.row_end   = last_col;
    push.item.frame_end = last_col && last_row;
  end

  // Advance the raster position, wrapping at row and frame ends
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      column_phase <= '0;
      row_phase    <= '0;
    end else if (accept) begin
      if ({1'b0, cc} >= w_cl - ddd_pkg::SIZE_W'(1)) begin
        column_count <= '0;
        column_phase <= '0;
        if ({1'b0, rc} >= h_cl - ddd_pkg::SIZE_W'(1)) begin
          row_count <= '0;
          row_phase <= '0;
        end else begin
          row_count <= rc + 1'b1;
          row_phase <= ({1'b0, rp} + 5'd1 >= rs_cl) ? '0 : rp + 1'b1;
        end
      end else begin
        column_count <= cc + 1'b1;
        column_phase <= ({1'b0, cp} + 5'd1 >= cs_cl) ? '0 : cp + 1'b1;
        row_count    <= rc;
        row_phase    <= rp;
      end
    end
  end

  `DDD_ASSERT(a_write_stalls, cfg_touch |=> in_stall, "input taken during limit setup")

endmodule

// File: src/ddd_queue.sv
// Short word queue between the front end and the back end
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ddd_queue (
  input  logic           clk,
  input  logic           rst,
  input  ddd_pkg::push_t push,
  output logic           full,
  input  logic           pop,
  output ddd_pkg::head_t head
);

  ddd_pkg::item_t                  mem [ddd_pkg::QUEUE_DEPTH];
  logic [ddd_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [ddd_pkg::QUEUE_CNT_W-1:0] count;

  assign full       = (count == ddd_pkg::QUEUE_CNT_W'(ddd_pkg::QUEUE_DEPTH));
  assign head.avail = (count != '0);
  assign head.item  = mem[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push.push) mem[wr_ptr] <= push.item;
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `DDD_ASSERT(a_no_push_full, !(push.push && full), "push into full queue")
  `DDD_ASSERT(a_level, count <= ddd_pkg::QUEUE_CNT_W'(ddd_pkg::QUEUE_DEPTH),
              "queue level out of range")

endmodule

// File: src/ddd_back.sv
// Back end: disparity divider and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ddd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  ddd_pkg::cfg_t                cfg,
  input  ddd_pkg::head_t               head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ddd_pkg::VALUE_W-1:0]  pixel_value,
  output logic                         invalid,
  output logic                         row_end,
  output logic                         frame_end
);

  ddd_pkg::back_state_t            state, state_next;
  logic [ddd_pkg::DEPTH_W-1:0]     rem, den, rem_next;
  logic [ddd_pkg::VALUE_W-1:0]     quo, quo_next;
  logic [ddd_pkg::DEPTH_W:0]       trial;
  logic                            ge;
  logic [ddd_pkg::DIV_CNT_W-1:0]   dcnt;
  logic                            hold_row_end, hold_frame_end;
  logic                            out_free, direct;
  logic                            start, step, load_direct, load_quo;
  logic [ddd_pkg::VALUE_W-1:0]     quo_result;

  assign out_free = !out_valid || !out_stall;
  assign direct   = !cfg.output_mode || head.item.bad;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial    = {rem, quo[ddd_pkg::VALUE_W-1]};
    ge       = (trial >= {1'b0, den});
    rem_next = ge ? ddd_pkg::DEPTH_W'(trial - {1'b0, den}) : trial[ddd_pkg::DEPTH_W-1:0];
    quo_next = {quo[ddd_pkg::VALUE_W-2:0], ge};
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) state <= ddd_pkg::BK_IDLE;
    else state <= state_next;
  end

  // Sequence: take a word, divide if needed, hand over to the output register
  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    start       = 1'b0;
    step        = 1'b0;
    load_direct = 1'b0;
    load_quo    = 1'b0;
    quo_result  = quo;
    case (state)
      ddd_pkg::BK_IDLE: begin
        if (head.avail && (!direct || out_free)) begin
          pop = 1'b1;
          if (direct) begin
            load_direct = 1'b1;
          end else begin
            start      = 1'b1;
            state_next = ddd_pkg::BK_DIV;
          end
        end
      end
      ddd_pkg::BK_DIV: begin
        step       = 1'b1;
        quo_result = quo_next;
        if (dcnt == ddd_pkg::DIV_CNT_W'(ddd_pkg::DIV_STEPS - 1)) begin
          if (out_free) begin
            load_quo   = 1'b1;
            state_next = ddd_pkg::BK_IDLE;
          end else begin
            state_next = ddd_pkg::BK_DONE;
          end
        end
      end
      ddd_pkg::BK_DONE: begin
        if (out_free) begin
          load_quo   = 1'b1;
          state_next = ddd_pkg::BK_IDLE;
        end
      end
      default: state_next = ddd_pkg::BK_IDLE;
    endcase
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem            <= '0;
      den            <= head.item.depth;
      quo            <= cfg.disparity_scale;
      dcnt           <= '0;
      hold_row_end   <= head.item.row_end;
      hold_frame_end <= head.item.frame_end;
    end else if (step) begin
      rem  <= rem_next;
      quo  <= quo_next;
      dcnt <= dcnt + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_direct || load_quo) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      pixel_value <= head.item.bad ? '0 : ddd_pkg::VALUE_W'(head.item.depth);
      invalid     <= head.item.bad;
      row_end     <= head.item.row_end;
      frame_end   <= head.item.frame_end;
    end else if (load_quo) begin
      pixel_value <= quo_result;
      invalid     <= 1'b0;
      row_end     <= hold_row_end;
      frame_end   <= hold_frame_end;
    end
  end

  `DDD_ASSERT(a_no_overwrite, !((load_direct || load_quo) && out_valid && out_stall),
              "output word overwritten while stalled")
  `DDD_ASSERT(a_pop_avail, pop |-> (head.avail && state == ddd_pkg::BK_IDLE),
              "pop from empty queue or while busy")

endmodule

// File: src/depth_decimate_disparity.sv
// Depth words and invalid samples go from the queue straight into the output register.
// Disparity words are taken from the queue, then pass through a 32-step restoring divider.
// One word per cycle in depth mode while no stall holds it; the divider takes a new disparity
// word only when idle. A 4-word queue lets the input keep flowing while the divider works.
// Reset (rst, synchronous): registers take their defaults, counters clear; then, and again
// after every register write, the block-limit setup holds in_stall high until it is done.
`timescale 1ns / 1ps
module depth_decimate_disparity (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ddd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ddd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ddd_pkg::DEPTH_W-1:0]      depth_sample,
  input  logic                             frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ddd_pkg::VALUE_W-1:0]      pixel_value,
  output logic                             invalid,
  output logic                             row_end,
  output logic                             frame_end
);

  ddd_pkg::cfg_t  cfg;
  ddd_pkg::push_t push;
  ddd_pkg::head_t head;
  logic           q_full, pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_mode     <= 1'b0;
      cfg.source_width    <= ddd_pkg::SIZE_W'(640);
      cfg.source_height   <= ddd_pkg::SIZE_W'(480);
      cfg.column_step     <= ddd_pkg::STEP_W'(1);
      cfg.row_step        <= ddd_pkg::STEP_W'(1);
      cfg.no_sample_code  <= '0;
      cfg.shadow_code     <= '0;
      cfg.disparity_scale <= '0;
    end else if (cfg_wr_en) begin
      case (ddd_pkg::cfg_reg_t'(cfg_index))
        ddd_pkg::REG_OUTPUT_MODE:     cfg.output_mode     <= cfg_data[0];
        ddd_pkg::REG_SOURCE_WIDTH:    cfg.source_width    <= cfg_data[ddd_pkg::SIZE_W-1:0];
        ddd_pkg::REG_SOURCE_HEIGHT:   cfg.source_height   <= cfg_data[ddd_pkg::SIZE_W-1:0];
        ddd_pkg::REG_COLUMN_STEP:     cfg.column_step     <= cfg_data[ddd_pkg::STEP_W-1:0];
        ddd_pkg::REG_ROW_STEP:        cfg.row_step        <= cfg_data[ddd_pkg::STEP_W-1:0];
        ddd_pkg::REG_NO_SAMPLE_CODE:  cfg.no_sample_code  <= cfg_data[ddd_pkg::DEPTH_W-1:0];
        ddd_pkg::REG_SHADOW_CODE:     cfg.shadow_code     <= cfg_data[ddd_pkg::DEPTH_W-1:0];
        ddd_pkg::REG_DISPARITY_SCALE: cfg.disparity_scale <= cfg_data[ddd_pkg::VALUE_W-1:0];
        default:                      cfg.output_mode     <= cfg.output_mode;
      endcase
    end
  end

  ddd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cfg_touch    (cfg_wr_en),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .depth_sample (depth_sample),
    .frame_start  (frame_start),
    .push         (push),
    .q_full       (q_full)
  );

  ddd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  ddd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_value (pixel_value),
    .invalid     (invalid),
    .row_end     (row_end),
    .frame_end   (frame_end)
  );

endmodule
